@@ rtl/core/rpac_pkg.sv @@
package rpac_pkg;

    localparam int COORD_BITS     = 24;
    localparam int COEF_FRAC_BITS = 16;

    localparam int COEF_W  = COEF_FRAC_BITS + 2;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = DIFF_W + COEF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = ACC_W - COEF_FRAC_BITS;
    localparam int SUM_W   = RND_W + 1;
    localparam int ANGLE_W = 9;
    localparam int TAB_W   = 7;
    localparam int TAB_N   = 91;

    localparam int IN_DATA_W  = 4 * COORD_BITS;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ANGLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_DEG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_CW    = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 9'd90;
    localparam logic               DIR_RESET   = 1'b1;

    localparam logic [63:0] PI_Q31 = 64'd6746518852;

    typedef logic [COEF_W-1:0] t_coef_tab [0:TAB_N-1];

    typedef struct packed {
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] s;
    } t_coef;

    localparam logic [63:0] TERM_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // sine of whole degrees 0..90, odd series in q31, rounded to coefficient format
    function automatic t_coef_tab build_coef_tab();
        t_coef_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] acc;
        int                 k;
        int                 n;
        for (k = 0; k < TAB_N; k++) begin
            if (k == 0) begin
                v = 64'd0;
            end else if (k == 30) begin
                v = 64'd1 << 30;
            end else if (k == 90) begin
                v = 64'd1 << 31;
            end else begin
                x    = (64'(k) * PI_Q31 + 64'd90) / 64'd180;
                x2   = (x * x) >> 31;
                acc  = $signed(x);
                term = x;
                for (n = 1; n <= 12; n++) begin
                    term = ((term * x2) >> 31) / TERM_DIV[n];
                    if (n % 2 == 1) begin
                        acc = acc - $signed(term);
                    end else begin
                        acc = acc + $signed(term);
                    end
                end
                if (acc < 0) begin
                    acc = 64'sd0;
                end
                if (acc > $signed(64'd1 << 31)) begin
                    acc = $signed(64'd1 << 31);
                end
                v = $unsigned(acc);
            end
            tab[k] = COEF_W'((v + (64'd1 << (30 - COEF_FRAC_BITS))) >> (31 - COEF_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_TAB = build_coef_tab();

endpackage

@@ rtl/core/rpac_coef.sv @@
module rpac_coef (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rpac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpac_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rpac_pkg::t_coef                    o_coef
);
    import rpac_pkg::*;

    logic [ANGLE_W-1:0] r_angle;
    logic               r_dir;
    t_coef              r_coef;
    t_coef              n_coef;

    logic [ANGLE_W-1:0] ang;
    logic [ANGLE_W-1:0] idx_s_full;
    logic [ANGLE_W-1:0] idx_c_full;
    logic               neg_s;
    logic               neg_c;
    logic [COEF_W-1:0]  mag_s;
    logic [COEF_W-1:0]  mag_c;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= ANGLE_RESET;
            r_dir   <= DIR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ANGLE_DEG: r_angle <= i_cfg_data;
                REG_DIR_CW:    r_dir   <= i_cfg_data[0];
                default:       r_angle <= r_angle;
            endcase
        end
    end

    always_comb begin
        ang = (r_angle >= 9'd360) ? r_angle - 9'd360 : r_angle;
        if (ang <= 9'd90) begin
            idx_s_full = ang;
            idx_c_full = 9'd90 - ang;
            neg_s      = 1'b0;
            neg_c      = 1'b0;
        end else if (ang <= 9'd180) begin
            idx_s_full = 9'd180 - ang;
            idx_c_full = ang - 9'd90;
            neg_s      = 1'b0;
            neg_c      = 1'b1;
        end else if (ang <= 9'd270) begin
            idx_s_full = ang - 9'd180;
            idx_c_full = 9'd270 - ang;
            neg_s      = 1'b1;
            neg_c      = 1'b1;
        end else begin
            idx_s_full = 9'd360 - ang;
            idx_c_full = ang - 9'd270;
            neg_s      = 1'b1;
            neg_c      = 1'b0;
        end
        mag_s    = COEF_TAB[idx_s_full[TAB_W-1:0]];
        mag_c    = COEF_TAB[idx_c_full[TAB_W-1:0]];
        // anticlockwise flips the sine sign
        n_coef.s = (neg_s ^ ~r_dir) ? -$signed(mag_s) : $signed(mag_s);
        n_coef.c = neg_c ? -$signed(mag_c) : $signed(mag_c);
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

@@ rtl/core/rotate_point_about_center_top.sv @@
// Rotates a point about a centre by the configured whole-degree angle, clockwise or
// anticlockwise with screen y pointing down, using sine and cosine coefficients with
// 16 fraction bits, rounding half away from zero and saturating to 24-bit coordinates.
// Input tdata carries point_x, point_y, center_x, center_y from the lowest bit up;
// output tdata carries new_x and new_y, and tuser the clipped flag. The datapath is a
// five-stage pipeline (offsets, products, sums, rounding, recentre and saturate): one
// item enters per clock unless a stalled output holds the pipeline, with backpressure
// handled per stage so bubbles close up. The coefficients are looked up from the angle
// register and registered once, so a configuration write reaches the datapath via both.
module rotate_point_about_center_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // point_x, point_y, center_x, center_y
    input  logic [rpac_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // new_x, new_y
    output logic [rpac_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // clipped
    output logic                                 o_m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rpac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rpac_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rpac_pkg::*;

    localparam int NSTG = 5;

    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    t_coef coef;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic signed [COORD_BITS-1:0] px, py, cx, cy;

    logic signed [DIFF_W-1:0]     r1_dx, r1_dy;
    logic signed [COORD_BITS-1:0] r1_cx, r1_cy;
    logic signed [PROD_W-1:0]     r2_xc, r2_ys, r2_xs, r2_yc;
    logic signed [COORD_BITS-1:0] r2_cx, r2_cy;
    logic signed [ACC_W-1:0]      r3_ax, r3_ay;
    logic signed [COORD_BITS-1:0] r3_cx, r3_cy;
    logic signed [RND_W-1:0]      r4_rx, r4_ry;
    logic signed [COORD_BITS-1:0] r4_cx, r4_cy;
    logic signed [COORD_BITS-1:0] r5_nx, r5_ny;
    logic                         r5_clip;

    logic signed [ACC_W-1:0] n4_bx, n4_by;
    logic signed [SUM_W-1:0] n5_sx, n5_sy;
    logic signed [COORD_BITS-1:0] n5_nx, n5_ny;
    logic                         n5_clip;

    rpac_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    assign px = i_s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign py = i_s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign cx = i_s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign cy = i_s_axis_tdata[3*COORD_BITS +: COORD_BITS];

    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n4_bx = r3_ax + $signed(r3_ax[ACC_W-1] ? HALF - ACC_W'(1) : HALF);
        n4_by = r3_ay + $signed(r3_ay[ACC_W-1] ? HALF - ACC_W'(1) : HALF);
        n5_sx = SUM_W'(r4_rx) + SUM_W'(r4_cx);
        n5_sy = SUM_W'(r4_ry) + SUM_W'(r4_cy);
        n5_clip = 1'b0;
        if (n5_sx > SAT_HI) begin
            n5_nx   = SAT_HI[COORD_BITS-1:0];
            n5_clip = 1'b1;
        end else if (n5_sx < SAT_LO) begin
            n5_nx   = SAT_LO[COORD_BITS-1:0];
            n5_clip = 1'b1;
        end else begin
            n5_nx = n5_sx[COORD_BITS-1:0];
        end
        if (n5_sy > SAT_HI) begin
            n5_ny   = SAT_HI[COORD_BITS-1:0];
            n5_clip = 1'b1;
        end else if (n5_sy < SAT_LO) begin
            n5_ny   = SAT_LO[COORD_BITS-1:0];
            n5_clip = 1'b1;
        end else begin
            n5_ny = n5_sy[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_dx <= DIFF_W'(px) - DIFF_W'(cx);
            r1_dy <= DIFF_W'(py) - DIFF_W'(cy);
            r1_cx <= cx;
            r1_cy <= cy;
        end
        if (en[1]) begin
            r2_xc <= r1_dx * coef.c;
            r2_ys <= r1_dy * coef.s;
            r2_xs <= r1_dx * coef.s;
            r2_yc <= r1_dy * coef.c;
            r2_cx <= r1_cx;
            r2_cy <= r1_cy;
        end
        if (en[2]) begin
            r3_ax <= ACC_W'(r2_xc) - ACC_W'(r2_ys);
            r3_ay <= ACC_W'(r2_xs) + ACC_W'(r2_yc);
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
        end
        if (en[3]) begin
            r4_rx <= n4_bx[ACC_W-1:COEF_FRAC_BITS];
            r4_ry <= n4_by[ACC_W-1:COEF_FRAC_BITS];
            r4_cx <= r3_cx;
            r4_cy <= r3_cy;
        end
        if (en[4]) begin
            r5_nx   <= n5_nx;
            r5_ny   <= n5_ny;
            r5_clip <= n5_clip;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = OUT_DATA_W'({r5_ny, r5_nx});
    assign o_m_axis_tuser  = r5_clip;

endmodule
